[rtl/look_at_view_matrix_macros.svh]
// ----------------------------------------------------------------------------
// look_at_view_matrix_macros
// Assertion macros for the look-at view matrix block.
// ----------------------------------------------------------------------------
`ifndef LOOK_AT_VIEW_MATRIX_MACROS_SVH
`define LOOK_AT_VIEW_MATRIX_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define LAV_ASSERT_NOW(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("look_at_view_matrix: check failed");
// next-cycle implication
`define LAV_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("look_at_view_matrix: check failed");
`else
`define LAV_ASSERT_NOW(label, clk, rst, pre, post)
`define LAV_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

[rtl/lav_pkg.sv]
// ----------------------------------------------------------------------------
// lav_pkg
// Shared widths and codes of the look-at view matrix pipeline.
// ----------------------------------------------------------------------------
package lav_pkg;
   localparam int WORD_W        = 32;
   localparam int FRAC_W        = 16;
   localparam int MAG_W         = 30;                 // prescaled magnitude
   localparam int SQ_W          = 2 * MAG_W + 2;      // sum of three squares
   localparam int LEN_W         = MAG_W + 1;          // vector length
   localparam int QUO_W         = FRAC_W + 1;         // unit component magnitude
   localparam int NUM_W         = MAG_W + QUO_W;      // divider numerator
   localparam int UNIT_W        = QUO_W + 1;          // signed unit component
   localparam int STEPS_PER_STG = 4;                  // digit steps per stage
   localparam int U_W           = 21;                 // rounded true-up component
   localparam int DS_W          = 36;                 // rounded s.eye and f.eye
   localparam int DU_W          = 39;                 // rounded u.eye
   localparam int ROW_W         = 2;

   typedef logic signed [UNIT_W-1:0] unit_type;

   typedef enum logic [ROW_W-1:0] {
      ROW_SIDE = 2'd0,
      ROW_UP   = 2'd1,
      ROW_BACK = 2'd2,
      ROW_LAST = 2'd3
   } row_type;
endpackage

[rtl/lav_sqrt.sv]
// ----------------------------------------------------------------------------
// lav_sqrt
// Pipelined digit-by-digit integer square root, a few root bits per stage.
// ----------------------------------------------------------------------------
module lav_sqrt #(
   parameter int SIDE_W = 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       vld_in,
   input  logic [lav_pkg::SQ_W-1:0]   rad_in,
   input  logic [SIDE_W-1:0]          side_in,
   output logic                       vld_out,
   output logic [lav_pkg::LEN_W-1:0]  root_out,
   output logic [SIDE_W-1:0]          side_out
);
   import lav_pkg::*;

   localparam int REM_W = LEN_W + 3;
   localparam int NSTG  = (LEN_W + STEPS_PER_STG - 1) / STEPS_PER_STG;

   logic             vld_ff  [NSTG];
   logic [REM_W-1:0] rem_ff  [NSTG];
   logic [REM_W-1:0] rem_in  [NSTG];
   logic [LEN_W-1:0] root_ff [NSTG];
   logic [LEN_W-1:0] root_in [NSTG];
   logic [SQ_W-1:0]  dig_ff  [NSTG];
   logic [SQ_W-1:0]  dig_in  [NSTG];
   logic [SIDE_W-1:0] side_ff [NSTG];

   for (genvar g = 0; g < NSTG; g++) begin : g_stg
      logic              vld_p;
      logic [REM_W-1:0]  rem_p;
      logic [LEN_W-1:0]  root_p;
      logic [SQ_W-1:0]   dig_p;
      logic [SIDE_W-1:0] side_p;

      if (g == 0) begin : g_first
         assign vld_p  = vld_in;
         assign rem_p  = '0;
         assign root_p = '0;
         assign dig_p  = rad_in;
         assign side_p = side_in;
      end else begin : g_next
         assign vld_p  = vld_ff[g-1];
         assign rem_p  = rem_ff[g-1];
         assign root_p = root_ff[g-1];
         assign dig_p  = dig_ff[g-1];
         assign side_p = side_ff[g-1];
      end

      always_comb begin
         logic [REM_W-1:0] r;
         logic [REM_W-1:0] r2;
         logic [REM_W-1:0] t;
         logic [LEN_W-1:0] q;
         logic [SQ_W-1:0]  d;
         r = rem_p;
         q = root_p;
         d = dig_p;
         for (int j = 0; j < STEPS_PER_STG; j++) begin
            if (g * STEPS_PER_STG + j < LEN_W) begin
               r2 = {r[REM_W-3:0], d[SQ_W-1 -: 2]};
               d  = {d[SQ_W-3:0], 2'b00};
               t  = {1'b0, q, 2'b01};
               if (r2 >= t) begin
                  r = r2 - t;
                  q = {q[LEN_W-2:0], 1'b1};
               end else begin
                  r = r2;
                  q = {q[LEN_W-2:0], 1'b0};
               end
            end
         end
         rem_in[g]  = r;
         root_in[g] = q;
         dig_in[g]  = d;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g] <= 1'b0;
         end else if (en) begin
            vld_ff[g] <= vld_p;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[g]  <= rem_in[g];
            root_ff[g] <= root_in[g];
            dig_ff[g]  <= dig_in[g];
            side_ff[g] <= side_p;
         end
      end
   end

   assign vld_out  = vld_ff[NSTG-1];
   assign root_out = root_ff[NSTG-1];
   assign side_out = side_ff[NSTG-1];
endmodule

[rtl/lav_div.sv]
// ----------------------------------------------------------------------------
// lav_div
// Three-lane pipelined restoring divider sharing one divisor.
// ----------------------------------------------------------------------------
module lav_div #(
   parameter int SIDE_W = 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       vld_in,
   input  logic [lav_pkg::NUM_W-1:0]  num_in [3],
   input  logic [lav_pkg::LEN_W-1:0]  den_in,
   input  logic [SIDE_W-1:0]          side_in,
   output logic                       vld_out,
   output logic [lav_pkg::QUO_W-1:0]  quo_out [3],
   output logic [SIDE_W-1:0]          side_out
);
   import lav_pkg::*;

   localparam int NSTG = (QUO_W + STEPS_PER_STG - 1) / STEPS_PER_STG;

   logic              vld_ff  [NSTG];
   logic [LEN_W-1:0]  den_ff  [NSTG];
   logic [LEN_W-1:0]  rem_ff  [NSTG][3];
   logic [LEN_W-1:0]  rem_in  [NSTG][3];
   logic [QUO_W-1:0]  lo_ff   [NSTG][3];
   logic [QUO_W-1:0]  lo_in   [NSTG][3];
   logic [QUO_W-1:0]  quo_ff  [NSTG][3];
   logic [QUO_W-1:0]  quo_in  [NSTG][3];
   logic [SIDE_W-1:0] side_ff [NSTG];

   for (genvar g = 0; g < NSTG; g++) begin : g_stg
      logic              vld_p;
      logic [LEN_W-1:0]  den_p;
      logic [LEN_W-1:0]  rem_p [3];
      logic [QUO_W-1:0]  lo_p  [3];
      logic [QUO_W-1:0]  quo_p [3];
      logic [SIDE_W-1:0] side_p;

      if (g == 0) begin : g_first
         // quotient fits QUO_W bits, so the high part starts below the divisor
         for (genvar k = 0; k < 3; k++) begin : g_lane
            assign rem_p[k] = LEN_W'(num_in[k][NUM_W-1:QUO_W]);
            assign lo_p[k]  = num_in[k][QUO_W-1:0];
            assign quo_p[k] = '0;
         end
         assign vld_p  = vld_in;
         assign den_p  = den_in;
         assign side_p = side_in;
      end else begin : g_next
         for (genvar k = 0; k < 3; k++) begin : g_lane
            assign rem_p[k] = rem_ff[g-1][k];
            assign lo_p[k]  = lo_ff[g-1][k];
            assign quo_p[k] = quo_ff[g-1][k];
         end
         assign vld_p  = vld_ff[g-1];
         assign den_p  = den_ff[g-1];
         assign side_p = side_ff[g-1];
      end

      always_comb begin
         logic [LEN_W-1:0] r;
         logic [LEN_W:0]   r2;
         logic [QUO_W-1:0] lo;
         logic [QUO_W-1:0] q;
         for (int k = 0; k < 3; k++) begin
            r  = rem_p[k];
            lo = lo_p[k];
            q  = quo_p[k];
            for (int j = 0; j < STEPS_PER_STG; j++) begin
               if (g * STEPS_PER_STG + j < QUO_W) begin
                  r2 = {r, lo[QUO_W-1]};
                  lo = {lo[QUO_W-2:0], 1'b0};
                  if (r2 >= {1'b0, den_p}) begin
                     r = LEN_W'(r2 - {1'b0, den_p});
                     q = {q[QUO_W-2:0], 1'b1};
                  end else begin
                     r = r2[LEN_W-1:0];
                     q = {q[QUO_W-2:0], 1'b0};
                  end
               end
            end
            rem_in[g][k] = r;
            lo_in[g][k]  = lo;
            quo_in[g][k] = q;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g] <= 1'b0;
         end else if (en) begin
            vld_ff[g] <= vld_p;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            den_ff[g]  <= den_p;
            side_ff[g] <= side_p;
            for (int k = 0; k < 3; k++) begin
               rem_ff[g][k] <= rem_in[g][k];
               lo_ff[g][k]  <= lo_in[g][k];
               quo_ff[g][k] <= quo_in[g][k];
            end
         end
      end
   end

   assign vld_out  = vld_ff[NSTG-1];
   assign side_out = side_ff[NSTG-1];
   for (genvar k = 0; k < 3; k++) begin : g_out
      assign quo_out[k] = quo_ff[NSTG-1][k];
   end
endmodule

[rtl/lav_norm.sv]
// ----------------------------------------------------------------------------
// lav_norm
// Pipelined vector normalizer: prescale, sum of squares, root, divide.
// ----------------------------------------------------------------------------
module lav_norm #(
   parameter int IN_W   = 33,
   parameter int SIDE_W = 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     vld_in,
   input  logic signed [IN_W-1:0]   vec_in [3],
   input  logic [SIDE_W-1:0]        side_in,
   output logic                     vld_out,
   output lav_pkg::unit_type        q_out [3],
   output logic                     zero_out,
   output logic [SIDE_W-1:0]        side_out
);
   import lav_pkg::*;

   localparam int POS_W = $clog2(IN_W);
   localparam logic [POS_W-1:0] TOP_POS = POS_W'(MAG_W - 1);
   localparam int SQS_W = 3 * MAG_W + 4 + SIDE_W;
   localparam int DVS_W = SIDE_W + 4;

   // stage 1: magnitudes
   logic              vld1_ff;
   logic [IN_W-1:0]   mag1_ff [3];
   logic [2:0]        sgn1_ff;
   logic [SIDE_W-1:0] side1_ff;
   // stage 2: largest magnitude
   logic              vld2_ff;
   logic [IN_W-1:0]   mag2_ff [3];
   logic [IN_W-1:0]   mx2_ff;
   logic [IN_W-1:0]   mx2_in;
   logic [2:0]        sgn2_ff;
   logic [SIDE_W-1:0] side2_ff;
   // stage 3: shift amount
   logic              vld3_ff;
   logic [IN_W-1:0]   mag3_ff [3];
   logic [2:0]        sgn3_ff;
   logic              zero3_ff;
   logic              rsh3_ff;
   logic [POS_W-1:0]  amt3_ff;
   logic [POS_W-1:0]  pos3_in;
   logic [SIDE_W-1:0] side3_ff;
   // stage 4: prescaled magnitudes
   logic              vld4_ff;
   logic [MAG_W-1:0]  m4_ff [3];
   logic [2:0]        sgn4_ff;
   logic              zero4_ff;
   logic [SIDE_W-1:0] side4_ff;
   // stage 5: squares
   logic              vld5_ff;
   logic [MAG_W-1:0]  m5_ff [3];
   logic [2*MAG_W-1:0] sq5_ff [3];
   logic [2:0]        sgn5_ff;
   logic              zero5_ff;
   logic [SIDE_W-1:0] side5_ff;
   // stage 6: sum of squares
   logic              vld6_ff;
   logic [MAG_W-1:0]  m6_ff [3];
   logic [SQ_W-1:0]   sum6_ff;
   logic [2:0]        sgn6_ff;
   logic              zero6_ff;
   logic [SIDE_W-1:0] side6_ff;
   // root
   logic              sq_vld;
   logic [LEN_W-1:0]  sq_len;
   logic [SQS_W-1:0]  sq_side;
   // stage 7: divider operands
   logic              vld7_ff;
   logic [NUM_W-1:0]  num7_ff [3];
   logic [LEN_W-1:0]  den7_ff;
   logic [DVS_W-1:0]  dvs7_ff;
   // divide
   logic              dv_vld;
   logic [QUO_W-1:0]  dv_quo [3];
   logic [DVS_W-1:0]  dv_side;
   // stage 8: signed result
   logic              vld8_ff;
   unit_type          q8_ff [3];
   logic              zero8_ff;
   logic [SIDE_W-1:0] side8_ff;

   always_comb begin
      mx2_in = mag1_ff[0];
      for (int i = 1; i < 3; i++) begin
         if (mag1_ff[i] > mx2_in) mx2_in = mag1_ff[i];
      end
   end

   always_comb begin
      pos3_in = '0;
      for (int b = 0; b < IN_W; b++) begin
         if (mx2_ff[b]) pos3_in = POS_W'(b);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
         vld4_ff <= 1'b0;
         vld5_ff <= 1'b0;
         vld6_ff <= 1'b0;
         vld7_ff <= 1'b0;
         vld8_ff <= 1'b0;
      end else if (en) begin
         vld1_ff <= vld_in;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
         vld4_ff <= vld3_ff;
         vld5_ff <= vld4_ff;
         vld6_ff <= vld5_ff;
         vld7_ff <= sq_vld;
         vld8_ff <= dv_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            mag1_ff[i] <= vec_in[i][IN_W-1] ? IN_W'(-vec_in[i]) : IN_W'(vec_in[i]);
            sgn1_ff[i] <= vec_in[i][IN_W-1];
            mag2_ff[i] <= mag1_ff[i];
            mag3_ff[i] <= mag2_ff[i];
            m4_ff[i]   <= rsh3_ff ? MAG_W'(mag3_ff[i] >> amt3_ff)
                                  : MAG_W'(mag3_ff[i] << amt3_ff);
            m5_ff[i]   <= m4_ff[i];
            sq5_ff[i]  <= m4_ff[i] * m4_ff[i];
            m6_ff[i]   <= m5_ff[i];
            num7_ff[i] <= NUM_W'({sq_side[i*MAG_W +: MAG_W], {FRAC_W{1'b0}}})
                          + NUM_W'(sq_len >> 1);
            if (dv_side[3]) begin
               q8_ff[i] <= '0;
            end else if (dv_side[i]) begin
               q8_ff[i] <= -unit_type'(dv_quo[i]);
            end else begin
               q8_ff[i] <= unit_type'(dv_quo[i]);
            end
         end
         side1_ff <= side_in;
         mx2_ff   <= mx2_in;
         sgn2_ff  <= sgn1_ff;
         side2_ff <= side1_ff;
         // target leading one sits at bit MAG_W-1
         sgn3_ff  <= sgn2_ff;
         zero3_ff <= (mx2_ff == '0);
         rsh3_ff  <= (pos3_in > TOP_POS);
         amt3_ff  <= (pos3_in > TOP_POS) ? pos3_in - TOP_POS : TOP_POS - pos3_in;
         side3_ff <= side2_ff;
         sgn4_ff  <= sgn3_ff;
         zero4_ff <= zero3_ff;
         side4_ff <= side3_ff;
         sgn5_ff  <= sgn4_ff;
         zero5_ff <= zero4_ff;
         side5_ff <= side4_ff;
         sum6_ff  <= SQ_W'(sq5_ff[0]) + SQ_W'(sq5_ff[1]) + SQ_W'(sq5_ff[2]);
         sgn6_ff  <= sgn5_ff;
         zero6_ff <= zero5_ff;
         side6_ff <= side5_ff;
         den7_ff  <= sq_len;
         dvs7_ff  <= sq_side[SQS_W-1:3*MAG_W];
         zero8_ff <= dv_side[3];
         side8_ff <= dv_side[DVS_W-1:4];
      end
   end

   lav_sqrt #(
      .SIDE_W (SQS_W)
   ) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .vld_in   (vld6_ff),
      .rad_in   (sum6_ff),
      .side_in  ({side6_ff, zero6_ff, sgn6_ff, m6_ff[2], m6_ff[1], m6_ff[0]}),
      .vld_out  (sq_vld),
      .root_out (sq_len),
      .side_out (sq_side)
   );

   // a zero vector divides by zero here; its quotient is masked afterward
   lav_div #(
      .SIDE_W (DVS_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .vld_in   (vld7_ff),
      .num_in   (num7_ff),
      .den_in   (den7_ff),
      .side_in  (dvs7_ff),
      .vld_out  (dv_vld),
      .quo_out  (dv_quo),
      .side_out (dv_side)
   );

   assign vld_out  = vld8_ff;
   assign q_out    = q8_ff;
   assign zero_out = zero8_ff;
   assign side_out = side8_ff;
endmodule

[rtl/lav_rows.sv]
// ----------------------------------------------------------------------------
// lav_rows
// Saturates one finished matrix and sends it out as four row words.
// ----------------------------------------------------------------------------
module lav_rows (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_vld,
   output logic                          in_rdy,
   input  lav_pkg::unit_type             s_in [3],
   input  logic signed [lav_pkg::U_W-1:0] u_in [3],
   input  lav_pkg::unit_type             f_in [3],
   input  logic signed [lav_pkg::DS_W-1:0] ds_in,
   input  logic signed [lav_pkg::DU_W-1:0] du_in,
   input  logic signed [lav_pkg::DS_W-1:0] df_in,
   input  logic                          deg_in,
   output logic                          tvalid,
   input  logic                          tready,
   output logic [4*lav_pkg::WORD_W-1:0]  tdata,
   output logic                          tlast,
   output logic [2:0]                    tuser
);
   import lav_pkg::*;

   localparam logic [WORD_W-1:0] Q_ONE = WORD_W'(1 << FRAC_W);

   function automatic logic [WORD_W-1:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) begin
         return 32'h7fff_ffff;
      end else if (v < -64'sd2147483648) begin
         return 32'h8000_0000;
      end else begin
         return v[WORD_W-1:0];
      end
   endfunction

   logic              busy_ff;
   row_type           row_ff;
   logic              deg_ff;
   logic [WORD_W-1:0] ent_ff [3][4];
   logic [WORD_W-1:0] col [4];
   logic              take;

   assign in_rdy = !busy_ff || (tready && row_ff == ROW_LAST);
   assign take   = in_vld && in_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         row_ff  <= ROW_SIDE;
      end else if (take) begin
         busy_ff <= 1'b1;
         row_ff  <= ROW_SIDE;
      end else if (busy_ff && tready) begin
         if (row_ff == ROW_LAST) begin
            busy_ff <= 1'b0;
         end else begin
            row_ff <= row_type'(row_ff + 2'd1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         deg_ff <= deg_in;
         for (int i = 0; i < 3; i++) begin
            ent_ff[0][i] <= sat32(64'(s_in[i]));
            ent_ff[1][i] <= sat32(64'(u_in[i]));
            ent_ff[2][i] <= sat32(-64'(f_in[i]));
         end
         ent_ff[0][3] <= sat32(-64'(ds_in));
         ent_ff[1][3] <= sat32(-64'(du_in));
         ent_ff[2][3] <= sat32(64'(df_in));
      end
   end

   always_comb begin
      unique case (row_ff)
         ROW_SIDE: col = ent_ff[0];
         ROW_UP:   col = ent_ff[1];
         ROW_BACK: col = ent_ff[2];
         ROW_LAST: col = '{'0, '0, '0, Q_ONE};
         default:  col = '{'0, '0, '0, Q_ONE};
      endcase
   end

   assign tvalid = busy_ff;
   assign tdata  = {col[3], col[2], col[1], col[0]};
   assign tlast  = (row_ff == ROW_LAST);
   assign tuser  = {deg_ff, row_ff};
endmodule

[rtl/look_at_view_matrix.sv]
// ----------------------------------------------------------------------------
// look_at_view_matrix
// Right-handed look-at view matrix in signed Q16.16, emitted row by row.
// ----------------------------------------------------------------------------
// channel  dir  ports         word
// req      in   req_t*        eye, target, up vectors (288-bit tdata)
// rsp      out  rsp_t*        one matrix row per word, tlast on row 3
//
// Sustained request rate is set by the four-word row output.
// Path to the first row word: 21-stage up/f normalizers,
// 2 cross product stages, 21-stage s normalizer, 5 stages for u and the
// dot products, then the row register.
// Reset is synchronous and clears only valid and control state.
// A stall on rsp freezes the whole pipeline; no word is lost or repeated.
// ----------------------------------------------------------------------------
`include "look_at_view_matrix_macros.svh"

module look_at_view_matrix (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z
   input  logic [287:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // col0, col1, col2, col3
   output logic [127:0] rsp_tdata,
   output logic         rsp_tlast,
   // row_index[1:0], degenerate
   output logic [2:0]   rsp_tuser
);
   import lav_pkg::*;

   localparam int FSIDE_W = 3 * WORD_W;
   localparam int SSIDE_W = 3 * UNIT_W + 3 * WORD_W + 1;

   logic               en;
   logic signed [31:0] eye [3];
   logic signed [32:0] fw  [3];
   logic signed [32:0] upv [3];

   logic               up_vld;
   unit_type           up_q [3];
   logic               up_zero;
   logic               f_vld;
   unit_type           f_q [3];
   logic               f_zero;
   logic [FSIDE_W-1:0] f_side;

   // cross f x up
   logic               vld_x1_ff;
   logic signed [35:0] p_x1_ff [6];
   unit_type           f_x1_ff [3];
   logic [FSIDE_W-1:0] eye_x1_ff;
   logic               deg_x1_ff;
   logic               vld_x2_ff;
   logic signed [36:0] sx_x2_ff [3];
   unit_type           f_x2_ff [3];
   logic [FSIDE_W-1:0] eye_x2_ff;
   logic               deg_x2_ff;

   logic               s_vld;
   unit_type           s_q [3];
   logic               s_zero;
   logic [SSIDE_W-1:0] s_side;
   unit_type           f_n [3];
   logic signed [31:0] eye_n [3];

   // u = s x f and dot products
   logic               vld_c1_ff, vld_c2_ff, vld_c3_ff, vld_c4_ff, vld_c5_ff;
   logic signed [35:0] pu_c1_ff  [6];
   logic signed [49:0] pse_c1_ff [3];
   logic signed [49:0] pfe_c1_ff [3];
   logic signed [36:0] ux_c2_ff  [3];
   logic signed [51:0] ds_c2_ff;
   logic signed [51:0] df_c2_ff;
   logic signed [U_W-1:0] u_c3_ff [3];
   logic signed [DS_W-1:0] ds_c3_ff;
   logic signed [DS_W-1:0] df_c3_ff;
   logic signed [52:0] pue_c4_ff [3];
   logic signed [DU_W-1:0] du_c5_ff;
   logic signed [36:0] ux_rnd [3];
   logic signed [51:0] ds_rnd;
   logic signed [51:0] df_rnd;
   logic signed [54:0] du_rnd;

   unit_type           s_c1_ff [3], s_c2_ff [3], s_c3_ff [3], s_c4_ff [3], s_c5_ff [3];
   unit_type           f_c1_ff [3], f_c2_ff [3], f_c3_ff [3], f_c4_ff [3], f_c5_ff [3];
   logic signed [31:0] eye_c1_ff [3], eye_c2_ff [3], eye_c3_ff [3];
   logic signed [U_W-1:0] u_c4_ff [3], u_c5_ff [3];
   logic signed [DS_W-1:0] ds_c4_ff, ds_c5_ff, df_c4_ff, df_c5_ff;
   logic               deg_c1_ff, deg_c2_ff, deg_c3_ff, deg_c4_ff, deg_c5_ff;

   for (genvar i = 0; i < 3; i++) begin : g_in
      assign eye[i]   = req_tdata[i*WORD_W +: WORD_W];
      assign fw[i]    = 33'(signed'(req_tdata[(3+i)*WORD_W +: WORD_W])) - 33'(eye[i]);
      assign upv[i]   = 33'(signed'(req_tdata[(6+i)*WORD_W +: WORD_W]));
      assign f_n[i]   = s_side[i*UNIT_W +: UNIT_W];
      assign eye_n[i] = s_side[3*UNIT_W + i*WORD_W +: WORD_W];
      assign ux_rnd[i] = ux_c2_ff[i] + 37'sd32768;
   end

   assign req_tready = en;
   assign ds_rnd = ds_c2_ff + 52'sd32768;
   assign df_rnd = df_c2_ff + 52'sd32768;
   assign du_rnd = 55'(pue_c4_ff[0]) + 55'(pue_c4_ff[1]) + 55'(pue_c4_ff[2])
                   + 55'sd32768;

   lav_norm #(
      .IN_W   (33),
      .SIDE_W (1)
   ) u_norm_up (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .vld_in   (req_tvalid),
      .vec_in   (upv),
      .side_in  (1'b0),
      .vld_out  (up_vld),
      .q_out    (up_q),
      .zero_out (up_zero),
      .side_out ()
   );

   lav_norm #(
      .IN_W   (33),
      .SIDE_W (FSIDE_W)
   ) u_norm_f (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .vld_in   (req_tvalid),
      .vec_in   (fw),
      .side_in  (req_tdata[FSIDE_W-1:0]),
      .vld_out  (f_vld),
      .q_out    (f_q),
      .zero_out (f_zero),
      .side_out (f_side)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_x1_ff <= 1'b0;
         vld_x2_ff <= 1'b0;
         vld_c1_ff <= 1'b0;
         vld_c2_ff <= 1'b0;
         vld_c3_ff <= 1'b0;
         vld_c4_ff <= 1'b0;
         vld_c5_ff <= 1'b0;
      end else if (en) begin
         vld_x1_ff <= f_vld;
         vld_x2_ff <= vld_x1_ff;
         vld_c1_ff <= s_vld;
         vld_c2_ff <= vld_c1_ff;
         vld_c3_ff <= vld_c2_ff;
         vld_c4_ff <= vld_c3_ff;
         vld_c5_ff <= vld_c4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_x1_ff[0] <= f_q[1] * up_q[2];
         p_x1_ff[1] <= f_q[2] * up_q[1];
         p_x1_ff[2] <= f_q[2] * up_q[0];
         p_x1_ff[3] <= f_q[0] * up_q[2];
         p_x1_ff[4] <= f_q[0] * up_q[1];
         p_x1_ff[5] <= f_q[1] * up_q[0];
         f_x1_ff    <= f_q;
         eye_x1_ff  <= f_side;
         deg_x1_ff  <= up_zero | f_zero;

         for (int i = 0; i < 3; i++) begin
            sx_x2_ff[i] <= 37'(p_x1_ff[2*i]) - 37'(p_x1_ff[2*i+1]);
         end
         f_x2_ff   <= f_x1_ff;
         eye_x2_ff <= eye_x1_ff;
         deg_x2_ff <= deg_x1_ff;

         pu_c1_ff[0] <= s_q[1] * f_n[2];
         pu_c1_ff[1] <= s_q[2] * f_n[1];
         pu_c1_ff[2] <= s_q[2] * f_n[0];
         pu_c1_ff[3] <= s_q[0] * f_n[2];
         pu_c1_ff[4] <= s_q[0] * f_n[1];
         pu_c1_ff[5] <= s_q[1] * f_n[0];
         for (int i = 0; i < 3; i++) begin
            pse_c1_ff[i] <= s_q[i] * eye_n[i];
            pfe_c1_ff[i] <= f_n[i] * eye_n[i];
         end
         s_c1_ff   <= s_q;
         f_c1_ff   <= f_n;
         eye_c1_ff <= eye_n;
         deg_c1_ff <= s_side[SSIDE_W-1] | s_zero;

         for (int i = 0; i < 3; i++) begin
            ux_c2_ff[i] <= 37'(pu_c1_ff[2*i]) - 37'(pu_c1_ff[2*i+1]);
         end
         ds_c2_ff  <= 52'(pse_c1_ff[0]) + 52'(pse_c1_ff[1]) + 52'(pse_c1_ff[2]);
         df_c2_ff  <= 52'(pfe_c1_ff[0]) + 52'(pfe_c1_ff[1]) + 52'(pfe_c1_ff[2]);
         s_c2_ff   <= s_c1_ff;
         f_c2_ff   <= f_c1_ff;
         eye_c2_ff <= eye_c1_ff;
         deg_c2_ff <= deg_c1_ff;

         // round half up: floor((v + 2^15) / 2^16)
         for (int i = 0; i < 3; i++) begin
            u_c3_ff[i] <= ux_rnd[i][36:FRAC_W];
         end
         ds_c3_ff  <= ds_rnd[51:FRAC_W];
         df_c3_ff  <= df_rnd[51:FRAC_W];
         s_c3_ff   <= s_c2_ff;
         f_c3_ff   <= f_c2_ff;
         eye_c3_ff <= eye_c2_ff;
         deg_c3_ff <= deg_c2_ff;

         for (int i = 0; i < 3; i++) begin
            pue_c4_ff[i] <= u_c3_ff[i] * eye_c3_ff[i];
         end
         u_c4_ff   <= u_c3_ff;
         s_c4_ff   <= s_c3_ff;
         f_c4_ff   <= f_c3_ff;
         ds_c4_ff  <= ds_c3_ff;
         df_c4_ff  <= df_c3_ff;
         deg_c4_ff <= deg_c3_ff;

         du_c5_ff  <= du_rnd[54:FRAC_W];
         u_c5_ff   <= u_c4_ff;
         s_c5_ff   <= s_c4_ff;
         f_c5_ff   <= f_c4_ff;
         ds_c5_ff  <= ds_c4_ff;
         df_c5_ff  <= df_c4_ff;
         deg_c5_ff <= deg_c4_ff;
      end
   end

   lav_norm #(
      .IN_W   (37),
      .SIDE_W (SSIDE_W)
   ) u_norm_s (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .vld_in   (vld_x2_ff),
      .vec_in   (sx_x2_ff),
      .side_in  ({deg_x2_ff, eye_x2_ff, f_x2_ff[2], f_x2_ff[1], f_x2_ff[0]}),
      .vld_out  (s_vld),
      .q_out    (s_q),
      .zero_out (s_zero),
      .side_out (s_side)
   );

   lav_rows u_rows (
      .clock  (clock),
      .reset  (reset),
      .in_vld (vld_c5_ff),
      .in_rdy (en),
      .s_in   (s_c5_ff),
      .u_in   (u_c5_ff),
      .f_in   (f_c5_ff),
      .ds_in  (ds_c5_ff),
      .du_in  (du_c5_ff),
      .df_in  (df_c5_ff),
      .deg_in (deg_c5_ff),
      .tvalid (rsp_tvalid),
      .tready (rsp_tready),
      .tdata  (rsp_tdata),
      .tlast  (rsp_tlast),
      .tuser  (rsp_tuser)
   );

   `LAV_ASSERT_NOW(a_norm_align, clock, reset, 1'b1, up_vld == f_vld)
   `LAV_ASSERT_NEXT(a_row_follows, clock, reset, rsp_tvalid && rsp_tready && !rsp_tlast, rsp_tvalid)
   `LAV_ASSERT_NEXT(a_row_step, clock, reset, rsp_tvalid && rsp_tready && !rsp_tlast, rsp_tuser[1:0] == $past(rsp_tuser[1:0]) + 2'd1)
   `LAV_ASSERT_NEXT(a_first_row, clock, reset, vld_c5_ff && en, rsp_tvalid && rsp_tuser[1:0] == ROW_SIDE)
endmodule

[bench/tb_look_at_view_matrix.sv]
// ----------------------------------------------------------------------------
// tb_look_at_view_matrix
// Self-checking bench for the look-at view matrix block: a directed table of
// cameras, then random cameras, with every row word checked against a
// fixed-point predictor or typed-in rows. Both stream sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_look_at_view_matrix;
   import lav_pkg::*;

   localparam int N_RANDOM    = 210;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN       = 80;
   localparam logic [31:0] QONE = 32'sh0001_0000;

   typedef struct packed {
      logic [31:0] up_z, up_y, up_x;
      logic [31:0] tgt_z, tgt_y, tgt_x;
      logic [31:0] eye_z, eye_y, eye_x;
   } camera_t;

   typedef struct {
      row_type     row;
      logic [31:0] c0, c1, c2, c3;
      logic        last;
      logic        degen;
   } row_word_t;

   typedef struct {
      camera_t cam;
      logic    check_fixed;   // typed-in rows for the all-zero case below
      logic    fixed_degen;
   } cam_row_t;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [287:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;
   logic         rsp_tlast;
   logic [2:0]   rsp_tuser;

   row_word_t   matrix_rows_q[$];
   int          n_errors = 0;
   int          n_rows_seen = 0;
   int          n_degen_seen = 0;
   int          cycle_count = 0;
   logic        no_idle = 1'b0;
   logic        hold_off = 1'b0;

   look_at_view_matrix i_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor
   function automatic longint signed magnitude(longint signed v);
      return v < 0 ? -v : v;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res, bits;
      res  = 0;
      bits = 64'd1 << 62;
      while (bits > n) bits >>= 2;
      while (bits != 0) begin
         if (n >= res + bits) begin
            n  -= res + bits;
            res = (res >> 1) + bits;
         end else begin
            res >>= 1;
         end
         bits >>= 2;
      end
      return res;
   endfunction

   function automatic longint signed round_q16(longint signed v);
      longint signed t;
      t = v + 32768;
      return t >>> 16;   // arithmetic shift == floor division
   endfunction

   function automatic logic [31:0] clamp32(longint signed v);
      if (v > 64'sd2147483647) return 32'h7fff_ffff;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

   // returns 1 if the vector had zero length
   function automatic logic to_unit(input longint signed vin[3],
                                    output longint signed vout[3]);
      longint unsigned m[3], mx, acc, len, q;
      mx = 0;
      for (int i = 0; i < 3; i++) begin
         m[i] = magnitude(vin[i]);
         if (m[i] > mx) mx = m[i];
      end
      if (mx == 0) begin
         for (int i = 0; i < 3; i++) vout[i] = 0;
         return 1'b1;
      end
      while (mx >= (64'd1 << 30)) begin
         mx >>= 1;
         for (int i = 0; i < 3; i++) m[i] >>= 1;
      end
      while (mx < (64'd1 << 29)) begin
         mx <<= 1;
         for (int i = 0; i < 3; i++) m[i] <<= 1;
      end
      acc = 0;
      for (int i = 0; i < 3; i++) acc += m[i] * m[i];
      len = int_sqrt(acc);
      for (int i = 0; i < 3; i++) begin
         q = ((m[i] << 16) + (len >> 1)) / len;
         vout[i] = vin[i] < 0 ? -longint'(q) : longint'(q);
      end
      return 1'b0;
   endfunction

   function automatic void cross_vec(input longint signed a[3], input longint signed b[3],
                                     output longint signed r[3]);
      r[0] = a[1] * b[2] - a[2] * b[1];
      r[1] = a[2] * b[0] - a[0] * b[2];
      r[2] = a[0] * b[1] - a[1] * b[0];
   endfunction

   function automatic longint signed dot_eye(longint signed a[3], longint signed e[3]);
      return round_q16(a[0] * e[0] + a[1] * e[1] + a[2] * e[2]);
   endfunction

   task automatic predict_view_rows(camera_t cam);
      longint signed eye[3], fwd[3], upv[3], upn[3], f[3], sx[3], s[3], ux[3], u[3];
      logic degen;
      row_word_t w;
      eye[0] = $signed(cam.eye_x); eye[1] = $signed(cam.eye_y); eye[2] = $signed(cam.eye_z);
      fwd[0] = longint'($signed(cam.tgt_x)) - eye[0];
      fwd[1] = longint'($signed(cam.tgt_y)) - eye[1];
      fwd[2] = longint'($signed(cam.tgt_z)) - eye[2];
      upv[0] = $signed(cam.up_x); upv[1] = $signed(cam.up_y); upv[2] = $signed(cam.up_z);
      degen = to_unit(upv, upn);
      degen |= to_unit(fwd, f);
      cross_vec(f, upn, sx);
      degen |= to_unit(sx, s);
      cross_vec(s, f, ux);
      for (int i = 0; i < 3; i++) u[i] = round_q16(ux[i]);
      w.degen = degen;
      w.last  = 1'b0;
      w.row = ROW_SIDE;
      w.c0 = clamp32(s[0]); w.c1 = clamp32(s[1]); w.c2 = clamp32(s[2]);
      w.c3 = clamp32(-dot_eye(s, eye));
      matrix_rows_q.push_back(w);
      w.row = ROW_UP;
      w.c0 = clamp32(u[0]); w.c1 = clamp32(u[1]); w.c2 = clamp32(u[2]);
      w.c3 = clamp32(-dot_eye(u, eye));
      matrix_rows_q.push_back(w);
      w.row = ROW_BACK;
      w.c0 = clamp32(-f[0]); w.c1 = clamp32(-f[1]); w.c2 = clamp32(-f[2]);
      w.c3 = clamp32(dot_eye(f, eye));
      matrix_rows_q.push_back(w);
      w.row = ROW_LAST;
      w.c0 = '0; w.c1 = '0; w.c2 = '0; w.c3 = QONE;
      w.last = 1'b1;
      matrix_rows_q.push_back(w);
   endtask

   // all-zero camera: every vector degenerate, matrix is zero except row 3
   task automatic push_typed_rows(logic degen);
      row_word_t w;
      for (int r = 0; r < 4; r++) begin
         w.row   = row_type'(r);
         w.c0    = '0; w.c1 = '0; w.c2 = '0;
         w.c3    = (r == 3) ? QONE : '0;
         w.last  = (r == 3);
         w.degen = degen;
         matrix_rows_q.push_back(w);
      end
   endtask

   // ---------------------------------------------------------------- stimulus
   function automatic logic [31:0] rand_coord(int mode);
      case (mode)
         0: return $urandom;
         1: return $urandom_range(0, 32'h000f_ffff) - 32'h0008_0000;
         2: return ($urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000)
                   ^ $urandom_range(0, 255);
         default: return $urandom_range(0, 15) << 16;
      endcase
   endfunction

   function automatic camera_t random_camera();
      camera_t c;
      int mode;
      mode = $urandom_range(0, 9);
      mode = mode < 3 ? 0 : mode < 7 ? 1 : mode < 8 ? 2 : 3;
      c.eye_x = rand_coord(mode); c.eye_y = rand_coord(mode); c.eye_z = rand_coord(mode);
      c.tgt_x = rand_coord(mode); c.tgt_y = rand_coord(mode); c.tgt_z = rand_coord(mode);
      c.up_x  = rand_coord(mode); c.up_y  = rand_coord(mode); c.up_z  = rand_coord(mode);
      case ($urandom_range(0, 19))
         0: c.tgt_x = c.eye_x;                            // rarely: parallel forms
         1: begin c.tgt_x = c.eye_x; c.tgt_y = c.eye_y; c.tgt_z = c.eye_z; end
         2: begin c.up_x = c.tgt_x - c.eye_x; c.up_y = c.tgt_y - c.eye_y;
                  c.up_z = c.tgt_z - c.eye_z; end
         3: begin c.up_x = '0; c.up_y = '0; c.up_z = '0; end
         default: ;
      endcase
      return c;
   endfunction

   // valid stays up after the word is taken; the next call or the caller drops it
   task automatic send_camera(camera_t cam);
      while (!no_idle && $urandom_range(0, 99) < 17) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= cam;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_view_rows(cam);
      @(negedge clock);
   endtask

   task automatic send_row(cam_row_t r);
      send_camera(r.cam);
      if (r.check_fixed) begin
         // replace predicted rows with typed-in ones
         repeat (4) void'(matrix_rows_q.pop_back());
         push_typed_rows(r.fixed_degen);
      end
   endtask

   cam_row_t directed[$];

   function automatic camera_t cam_of(logic [31:0] ex, ey, ez, tx, ty, tz, ux, uy, uz);
      camera_t c;
      c.eye_x = ex; c.eye_y = ey; c.eye_z = ez;
      c.tgt_x = tx; c.tgt_y = ty; c.tgt_z = tz;
      c.up_x = ux; c.up_y = uy; c.up_z = uz;
      return c;
   endfunction

   task automatic add_row(camera_t c, logic fixed, logic degen);
      cam_row_t r;
      r.cam = c; r.check_fixed = fixed; r.fixed_degen = degen;
      directed.push_back(r);
   endtask

   initial begin
      localparam logic [31:0] MX = 32'h7fff_ffff;
      localparam logic [31:0] MN = 32'h8000_0000;
      localparam logic [31:0] M1 = 32'hffff_0000;
      localparam logic [31:0] ONE = 32'h0001_0000;
      int n_sent;
      add_row(cam_of(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, 1'b1);           // all zero
      add_row(cam_of(0, 0, 0, 0, 0, M1, 0, ONE, 0), 1'b0, 1'b0);        // canonical
      add_row(cam_of(0, 0, 0, 0, 0, ONE, 0, ONE, 0), 1'b0, 1'b0);
      add_row(cam_of(ONE, 2*ONE, 3*ONE, 0, 0, 0, 0, 0, ONE), 1'b0, 1'b0);
      add_row(cam_of(0, 0, 0, 0, 0, M1, 0, 0, 0), 1'b0, 1'b0);          // zero up
      add_row(cam_of(ONE, ONE, ONE, ONE, ONE, ONE, 0, ONE, 0), 1'b0, 1'b0); // eye==target
      add_row(cam_of(0, 0, 0, 0, ONE, 0, 0, ONE, 0), 1'b0, 1'b0);       // f parallel up
      add_row(cam_of(0, 0, 0, 0, 5*ONE, 0, 0, M1, 0), 1'b0, 1'b0);      // antiparallel
      add_row(cam_of(MN, MN, MN, MX, MX, MX, MX, MN, MX), 1'b0, 1'b0);  // widest f
      add_row(cam_of(MX, MX, MX, MN, MN, MN, MN, MX, MN), 1'b0, 1'b0);
      add_row(cam_of(MX, MN, MX, MN, MX, MN, 1, 0, 0), 1'b0, 1'b0);     // tiny up
      add_row(cam_of(0, 0, 0, 1, 0, 0, 0, 0, 1), 1'b0, 1'b0);           // tiny f
      add_row(cam_of(MX, 0, MN, MX, 1, MN, MX, MX, MX), 1'b0, 1'b0);
      add_row(cam_of(MN, MX, 0, 0, 0, 0, 0, MN, 0), 1'b0, 1'b0);        // saturating dot
      add_row(cam_of('1, '1, '1, 0, 0, 0, '1, 0, '1), 1'b0, 1'b0);
      add_row(cam_of(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
                     32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa,
                     32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555), 1'b0, 1'b0);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i]) send_row(directed[i]);
      req_tvalid <= 1'b0;

      // pause until the block is drained
      while (matrix_rows_q.size() != 0) @(negedge clock);

      // receiver holds off while cameras keep coming in
      hold_off <= 1'b1;
      for (n_sent = 0; n_sent < 30; n_sent++) send_camera(random_camera());

      no_idle <= 1'b1;
      for (n_sent = 0; n_sent < 50; n_sent++) send_camera(random_camera());
      no_idle <= 1'b0;
      for (n_sent = 0; n_sent < N_RANDOM - 80; n_sent++) send_camera(random_camera());
      req_tvalid <= 1'b0;

      while (matrix_rows_q.size() != 0) @(negedge clock);
      repeat (DRAIN) @(negedge clock);
      $display("Checked %0d matrix rows (%0d flagged degenerate) from %0d cameras.",
               n_rows_seen, n_degen_seen, directed.size() + N_RANDOM);
      if (n_errors == 0 && matrix_rows_q.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // ---------------------------------------------------------------- receiver
   initial begin
      int stall_cycles;
      // ready before the long hold-off so directed words drain
      forever begin
         @(negedge clock);
         if (hold_off) break;
         rsp_tready <= ($urandom_range(0, 99) >= 17);
      end
      rsp_tready <= 1'b0;
      for (stall_cycles = 0; stall_cycles < 300; stall_cycles++) @(negedge clock);
      forever begin
         rsp_tready <= no_idle || ($urandom_range(0, 99) >= 17);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      row_word_t exp_w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         n_rows_seen++;
         if (rsp_tuser[2]) n_degen_seen++;
         if (matrix_rows_q.size() == 0) begin
            $error("row word with no expectation: tdata=%h", rsp_tdata);
            n_errors++;
         end else begin
            exp_w = matrix_rows_q.pop_front();
            if (rsp_tuser[1:0] != exp_w.row) begin
               $error("row_index: expected %0d, got %0d", exp_w.row, rsp_tuser[1:0]);
               n_errors++;
            end
            if (rsp_tdata[31:0] != exp_w.c0) begin
               $error("col0: expected %h, got %h", exp_w.c0, rsp_tdata[31:0]);
               n_errors++;
            end
            if (rsp_tdata[63:32] != exp_w.c1) begin
               $error("col1: expected %h, got %h", exp_w.c1, rsp_tdata[63:32]);
               n_errors++;
            end
            if (rsp_tdata[95:64] != exp_w.c2) begin
               $error("col2: expected %h, got %h", exp_w.c2, rsp_tdata[95:64]);
               n_errors++;
            end
            if (rsp_tdata[127:96] != exp_w.c3) begin
               $error("col3: expected %h, got %h", exp_w.c3, rsp_tdata[127:96]);
               n_errors++;
            end
            if (rsp_tlast != exp_w.last) begin
               $error("last_row: expected %0b, got %0b", exp_w.last, rsp_tlast);
               n_errors++;
            end
            if (rsp_tuser[2] != exp_w.degen) begin
               $error("degenerate: expected %0b, got %0b", exp_w.degen, rsp_tuser[2]);
               n_errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end
endmodule

[look_at_view_matrix.f]
+incdir+rtl
rtl/lav_pkg.sv
rtl/lav_sqrt.sv
rtl/lav_div.sv
rtl/lav_norm.sv
rtl/lav_rows.sv
rtl/look_at_view_matrix.sv
bench/tb_look_at_view_matrix.sv
